// ===== rtl/core/giwm_pkg.sv =====
package giwm_pkg;

	// image geometry
	localparam int SIDE   = 256;
	localparam int RADIUS = 20;
	localparam int POS_W  = $clog2(SIDE);
	localparam int ADDR_W = $clog2(SIDE * SIDE);
	localparam int OFF_W  = $clog2(RADIUS) + 1;
	localparam int D2_W   = $clog2(2 * RADIUS * RADIUS + 1);

	// field widths
	localparam int DOSE_W  = 16;
	localparam int DIST_W  = 8;
	localparam int COORD_W = 8;
	localparam int MODE_W  = 2;
	localparam int IDX_W   = 2;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 40;

	// gamma^2 terms in Q32.24
	localparam int FRAC_SQ = 24;
	localparam int AD2_W   = 2 * DOSE_W;
	localparam int DEN_W   = 2 * DOSE_W;
	localparam int DIV_W   = AD2_W + FRAC_SQ;
	localparam int DCNT_W  = $clog2(DIV_W);

	// running minimum and its square root
	localparam int GAMMA_CAP = 40960;
	localparam int BEST_W    = $clog2(GAMMA_CAP * GAMMA_CAP + 1);
	localparam int SQ_TOP    = ((BEST_W - 1) / 2) * 2;
	localparam int ROOT_W    = BEST_W + 1;
	localparam int ONE_SQ    = 1 << FRAC_SQ;

	// pass counter
	localparam int COUNT_W   = 17;
	localparam int COUNT_MAX = (1 << COUNT_W) - 1;

	// request kinds
	localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EVAL   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// register indexes and reset values
	localparam logic [IDX_W-1:0]  CFG_DIST_CRIT = 2'd0;
	localparam logic [IDX_W-1:0]  CFG_DOSE_CRIT = 2'd1;
	localparam logic [DIST_W-1:0] DIST_CRIT_RST = 8'd30;
	localparam logic [DOSE_W-1:0] DOSE_CRIT_RST = 16'd123;

endpackage

// ===== rtl/core/gamma_index_window_min.sv =====
// Gamma-index window search over a reference and an evaluated dose image,
// each 256 by 256 pixels of unsigned Q4.12 held in on-chip memory and
// undefined until loaded. A load or clear request is answered straight
// from the emit state, as is an evaluation whose window leaves the image.
// An evaluation visits the 40 by 40 window entries one after another; for
// each entry the distance term goes through one restoring divider that
// retires one quotient bit per cycle (56 bits per term), and the dose term
// follows through the same divider only while the distance term alone stays
// below the running minimum. A bit-serial square root of the minimum
// ends the evaluation. Requests are taken one at a time; a finished
// result waits in the output register.
module gamma_index_window_min (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // row[7:0], col[15:8], ref_dose[31:16], eval_dose[47:32]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // gamma[15:0], passed[16], pass_count[33:17], edge_error[34]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_RD, S_DIFF, S_SQ, S_DIV, S_T1, S_T2, S_NEXT, S_SQRT, S_EMIT
	} state_t;

	state_t state_q;

	logic [giwm_pkg::DIST_W-1:0]  dist_crit_q;
	logic [giwm_pkg::DOSE_W-1:0]  dose_crit_q;
	logic [giwm_pkg::COORD_W-1:0] row_q, col_q;
	logic signed [giwm_pkg::OFF_W-1:0] dr_q, dc_q;
	logic [giwm_pkg::D2_W-1:0]    d2_q;
	logic [giwm_pkg::DOSE_W-1:0]  ad_q;
	logic [giwm_pkg::AD2_W-1:0]   ad2_q;
	logic [giwm_pkg::DOSE_W-1:0]  dist_den_q;
	logic [giwm_pkg::DEN_W-1:0]   dose_den_q;
	logic [giwm_pkg::BEST_W-1:0]  best_q;
	logic [giwm_pkg::DIV_W-1:0]   t1_q;
	logic [giwm_pkg::DIV_W-1:0]   div_num_q;
	logic [giwm_pkg::DEN_W-1:0]   div_den_q;
	logic [giwm_pkg::DEN_W-1:0]   rem_q;
	logic [giwm_pkg::DCNT_W-1:0]  div_cnt_q;
	logic                         div_term_q;
	logic [giwm_pkg::BEST_W-1:0]  sq_v_q;
	logic [giwm_pkg::ROOT_W-1:0]  sq_res_q, sq_bit_q;
	logic [giwm_pkg::DOSE_W-1:0]  res_gamma_q;
	logic                         res_passed_q, res_edge_q, res_clear_q;
	logic [giwm_pkg::COUNT_W-1:0] total_q;
	logic                         m_tvalid_q;
	logic [giwm_pkg::OUT_W-1:0]   m_tdata_q;

	logic [giwm_pkg::DOSE_W-1:0]  ref_rd_q, eval_rd_q;
	logic [giwm_pkg::DOSE_W-1:0]  ref_mem  [giwm_pkg::SIDE * giwm_pkg::SIDE];
	logic [giwm_pkg::DOSE_W-1:0]  eval_mem [giwm_pkg::SIDE * giwm_pkg::SIDE];

	// request fields
	logic [giwm_pkg::MODE_W-1:0]  in_mode;
	logic [giwm_pkg::COORD_W-1:0] in_row, in_col;
	logic [giwm_pkg::DOSE_W-1:0]  in_ref, in_eval;
	logic                         s_acc, in_range, in_edge;
	logic                         load_wr, center_rd, win_rd;
	logic [giwm_pkg::ADDR_W-1:0]  center_addr, win_addr;
	logic [giwm_pkg::POS_W-1:0]   pos_r, pos_c;

	assign in_mode = s_tuser;
	assign in_row  = s_tdata[7:0];
	assign in_col  = s_tdata[15:8];
	assign in_ref  = s_tdata[31:16];
	assign in_eval = s_tdata[47:32];

	assign s_tready  = (state_q == S_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign in_range = (int'(in_row) < giwm_pkg::SIDE) && (int'(in_col) < giwm_pkg::SIDE);
	assign in_edge  = (int'(in_row) < giwm_pkg::RADIUS) || (int'(in_col) < giwm_pkg::RADIUS) ||
	                  (int'(in_row) + giwm_pkg::RADIUS > giwm_pkg::SIDE) ||
	                  (int'(in_col) + giwm_pkg::RADIUS > giwm_pkg::SIDE);

	assign center_addr = giwm_pkg::ADDR_W'(in_row) * giwm_pkg::ADDR_W'(giwm_pkg::SIDE) +
	                     giwm_pkg::ADDR_W'(in_col);
	assign pos_r    = giwm_pkg::POS_W'(row_q) + giwm_pkg::POS_W'(dr_q);
	assign pos_c    = giwm_pkg::POS_W'(col_q) + giwm_pkg::POS_W'(dc_q);
	assign win_addr = giwm_pkg::ADDR_W'(pos_r) * giwm_pkg::ADDR_W'(giwm_pkg::SIDE) +
	                  giwm_pkg::ADDR_W'(pos_c);

	assign load_wr   = s_acc && (in_mode == giwm_pkg::MODE_LOAD) && in_range;
	assign center_rd = s_acc && (in_mode == giwm_pkg::MODE_EVAL);
	assign win_rd    = (state_q == S_RD);

	always_ff @(posedge clk) begin
		if (load_wr) begin
			ref_mem[center_addr] <= in_ref;
		end
		if (center_rd) begin
			ref_rd_q <= ref_mem[center_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load_wr) begin
			eval_mem[center_addr] <= in_eval;
		end
		if (win_rd) begin
			eval_rd_q <= eval_mem[win_addr];
		end
	end

	// criteria, zero taken as one
	logic [giwm_pkg::DIST_W-1:0] dc_eff;
	logic [giwm_pkg::DOSE_W-1:0] qc_eff;
	assign dc_eff = (dist_crit_q == '0) ? giwm_pkg::DIST_W'(1) : dist_crit_q;
	assign qc_eff = (dose_crit_q == '0) ? giwm_pkg::DOSE_W'(1) : dose_crit_q;

	// squared offsets
	logic signed [2*giwm_pkg::OFF_W-1:0] dr_sq, dc_sq;
	assign dr_sq = dr_q * dr_q;
	assign dc_sq = dc_q * dc_q;

	// restoring divider step
	logic [giwm_pkg::DEN_W:0]   rem_sh;
	logic                       div_ge;
	logic [giwm_pkg::DEN_W-1:0] rem_nx;
	assign rem_sh = {rem_q, div_num_q[giwm_pkg::DIV_W-1]};
	assign div_ge = rem_sh >= {1'b0, div_den_q};
	assign rem_nx = div_ge ? giwm_pkg::DEN_W'(rem_sh - {1'b0, div_den_q})
	                       : giwm_pkg::DEN_W'(rem_sh);

	// term compares
	logic                     t1_ge, sum_lt;
	logic [giwm_pkg::DIV_W:0] sum;
	assign t1_ge  = div_num_q >= giwm_pkg::DIV_W'(best_q);
	assign sum    = (giwm_pkg::DIV_W + 1)'(t1_q) + (giwm_pkg::DIV_W + 1)'(div_num_q);
	assign sum_lt = sum < (giwm_pkg::DIV_W + 1)'(best_q);

	// square root step
	logic [giwm_pkg::ROOT_W-1:0] sq_trial, sq_res_nx;
	logic                        sq_ge;
	assign sq_trial  = sq_res_q + sq_bit_q;
	assign sq_ge     = giwm_pkg::ROOT_W'(sq_v_q) >= sq_trial;
	assign sq_res_nx = sq_ge ? (sq_res_q >> 1) + sq_bit_q : (sq_res_q >> 1);

	logic last_c, last_r;
	assign last_c = (dc_q == giwm_pkg::OFF_W'(giwm_pkg::RADIUS - 1));
	assign last_r = (dr_q == giwm_pkg::OFF_W'(giwm_pkg::RADIUS - 1));

	logic [giwm_pkg::COUNT_W-1:0] total_nx;
	always_comb begin
		priority if (res_clear_q) begin
			total_nx = '0;
		end else if (res_passed_q && (total_q != giwm_pkg::COUNT_W'(giwm_pkg::COUNT_MAX))) begin
			total_nx = total_q + giwm_pkg::COUNT_W'(1);
		end else begin
			total_nx = total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			dist_crit_q  <= giwm_pkg::DIST_CRIT_RST;
			dose_crit_q  <= giwm_pkg::DOSE_CRIT_RST;
			total_q      <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			row_q        <= '0;
			col_q        <= '0;
			dr_q         <= '0;
			dc_q         <= '0;
			d2_q         <= '0;
			ad_q         <= '0;
			ad2_q        <= '0;
			dist_den_q   <= '0;
			dose_den_q   <= '0;
			best_q       <= '0;
			t1_q         <= '0;
			div_num_q    <= '0;
			div_den_q    <= '0;
			rem_q        <= '0;
			div_cnt_q    <= '0;
			div_term_q   <= 1'b0;
			sq_v_q       <= '0;
			sq_res_q     <= '0;
			sq_bit_q     <= '0;
			res_gamma_q  <= '0;
			res_passed_q <= 1'b0;
			res_edge_q   <= 1'b0;
			res_clear_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					giwm_pkg::CFG_DIST_CRIT: dist_crit_q <= cfg_data[giwm_pkg::DIST_W-1:0];
					giwm_pkg::CFG_DOSE_CRIT: dose_crit_q <= cfg_data;
					default: ;
				endcase
			end

			// the emit state drives the output register itself
			if (m_tvalid_q && m_tready && (state_q != S_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						row_q        <= in_row;
						col_q        <= in_col;
						res_gamma_q  <= '0;
						res_passed_q <= 1'b0;
						res_edge_q   <= 1'b0;
						res_clear_q  <= (in_mode == giwm_pkg::MODE_CLEAR);
						if (in_mode == giwm_pkg::MODE_EVAL && !in_edge) begin
							state_q <= S_PREP;
						end else begin
							res_edge_q <= (in_mode == giwm_pkg::MODE_EVAL);
							state_q    <= S_EMIT;
						end
					end
				end
				S_PREP: begin
					dist_den_q <= giwm_pkg::DOSE_W'(dc_eff) * giwm_pkg::DOSE_W'(dc_eff);
					dose_den_q <= giwm_pkg::DEN_W'(qc_eff) * giwm_pkg::DEN_W'(qc_eff);
					best_q     <= giwm_pkg::BEST_W'(giwm_pkg::GAMMA_CAP * giwm_pkg::GAMMA_CAP);
					dr_q       <= giwm_pkg::OFF_W'(-giwm_pkg::RADIUS);
					dc_q       <= giwm_pkg::OFF_W'(-giwm_pkg::RADIUS);
					state_q    <= S_RD;
				end
				S_RD: begin
					d2_q    <= giwm_pkg::D2_W'(unsigned'(dr_sq)) +
					           giwm_pkg::D2_W'(unsigned'(dc_sq));
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					ad_q    <= (eval_rd_q >= ref_rd_q) ? eval_rd_q - ref_rd_q
					                                   : ref_rd_q - eval_rd_q;
					state_q <= S_SQ;
				end
				S_SQ: begin
					ad2_q      <= giwm_pkg::AD2_W'(ad_q) * giwm_pkg::AD2_W'(ad_q);
					div_num_q  <= giwm_pkg::DIV_W'(d2_q) << giwm_pkg::FRAC_SQ;
					div_den_q  <= giwm_pkg::DEN_W'(dist_den_q);
					rem_q      <= '0;
					div_cnt_q  <= '0;
					div_term_q <= 1'b0;
					state_q    <= S_DIV;
				end
				S_DIV: begin
					rem_q     <= rem_nx;
					div_num_q <= {div_num_q[giwm_pkg::DIV_W-2:0], div_ge};
					div_cnt_q <= div_cnt_q + giwm_pkg::DCNT_W'(1);
					if (div_cnt_q == giwm_pkg::DCNT_W'(giwm_pkg::DIV_W - 1)) begin
						state_q <= div_term_q ? S_T2 : S_T1;
					end
				end
				S_T1: begin
					t1_q <= div_num_q;
					// distance term alone cannot beat the minimum: skip the dose term
					if (t1_ge) begin
						state_q <= S_NEXT;
					end else begin
						div_num_q  <= giwm_pkg::DIV_W'(ad2_q) << giwm_pkg::FRAC_SQ;
						div_den_q  <= dose_den_q;
						rem_q      <= '0;
						div_cnt_q  <= '0;
						div_term_q <= 1'b1;
						state_q    <= S_DIV;
					end
				end
				S_T2: begin
					if (sum_lt) begin
						best_q <= giwm_pkg::BEST_W'(sum);
					end
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (last_c) begin
						dc_q <= giwm_pkg::OFF_W'(-giwm_pkg::RADIUS);
						if (last_r) begin
							res_passed_q <= (giwm_pkg::ROOT_W'(best_q) <=
							                 giwm_pkg::ROOT_W'(giwm_pkg::ONE_SQ));
							sq_v_q   <= best_q;
							sq_res_q <= '0;
							sq_bit_q <= giwm_pkg::ROOT_W'(1) << giwm_pkg::SQ_TOP;
							state_q  <= S_SQRT;
						end else begin
							dr_q    <= dr_q + giwm_pkg::OFF_W'(1);
							state_q <= S_RD;
						end
					end else begin
						dc_q    <= dc_q + giwm_pkg::OFF_W'(1);
						state_q <= S_RD;
					end
				end
				S_SQRT: begin
					if (sq_ge) begin
						sq_v_q <= giwm_pkg::BEST_W'(giwm_pkg::ROOT_W'(sq_v_q) - sq_trial);
					end
					sq_res_q <= sq_res_nx;
					sq_bit_q <= sq_bit_q >> 2;
					if (sq_bit_q[0]) begin
						res_gamma_q <= sq_res_nx[giwm_pkg::DOSE_W-1:0];
						state_q     <= S_EMIT;
					end
				end
				S_EMIT: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= giwm_pkg::OUT_W'({res_edge_q, total_nx,
						                                res_passed_q, res_gamma_q});
						total_q    <= total_nx;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/sv/gamma_index_window_min_tb.sv =====
module gamma_index_window_min_tb;
	import giwm_pkg::*;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic [DOSE_W-1:0]  gamma;
		logic               passed;
		logic [COUNT_W-1:0] pass_count;
		logic               edge_error;
	} gamma_result_t;

	// fully loaded block; centers 120 and 121 have a written window in both axes
	localparam int BLK_LO = 100;
	localparam int BLK_HI = 140;
	localparam int CTR_LO = 120;
	localparam int CTR_HI = 121;
	localparam int HOLD_CYCLES = 200;

	class gamma_window_check;
		bit [DOSE_W-1:0]  ref_img  [SIDE*SIDE];
		bit [DOSE_W-1:0]  eval_img [SIDE*SIDE];
		bit [COUNT_W-1:0] pass_total;
		bit [DIST_W-1:0]  dist_crit;
		bit [DOSE_W-1:0]  dose_crit;
		gamma_result_t    pending_gammas[$];
		int               mismatches;

		function new();
			dist_crit  = DIST_CRIT_RST;
			dose_crit  = DOSE_CRIT_RST;
			pass_total = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [15:0] value);
			if (idx == CFG_DIST_CRIT)
				dist_crit = value[DIST_W-1:0];
			else if (idx == CFG_DOSE_CRIT)
				dose_crit = value[DOSE_W-1:0];
		endfunction

		// smallest gamma^2 in Q8.24 over the window, starting from the cap
		function u64_t min_gamma_sq(int row, int col);
			u64_t dist_den, dose_den, best, ad, t1, t2;
			int   center, diff, dr, dc;
			dist_den = (dist_crit == 0) ? u64_t'(1) : u64_t'(dist_crit) * u64_t'(dist_crit);
			dose_den = (dose_crit == 0) ? u64_t'(1) : u64_t'(dose_crit) * u64_t'(dose_crit);
			best     = u64_t'(GAMMA_CAP) * u64_t'(GAMMA_CAP);
			center   = ref_img[row*SIDE + col];
			for (dr = -RADIUS; dr < RADIUS; dr++) begin
				for (dc = -RADIUS; dc < RADIUS; dc++) begin
					diff = int'(eval_img[(row + dr)*SIDE + col + dc]) - center;
					ad   = u64_t'((diff < 0) ? -diff : diff);
					t1   = (u64_t'(dr*dr + dc*dc) << FRAC_SQ) / dist_den;
					t2   = ((ad * ad) << FRAC_SQ) / dose_den;
					if (t1 + t2 < best)
						best = t1 + t2;
				end
			end
			return best;
		endfunction

		function bit [DOSE_W-1:0] floor_root(u64_t v);
			u64_t r, trial;
			int   b;
			r = 0;
			for (b = DOSE_W-1; b >= 0; b--) begin
				trial = r | (u64_t'(1) << b);
				if (trial * trial <= v)
					r = trial;
			end
			return r[DOSE_W-1:0];
		endfunction

		function void note_request(logic [MODE_W-1:0] mode, int row, int col,
				logic [DOSE_W-1:0] rd, logic [DOSE_W-1:0] ed);
			gamma_result_t res;
			u64_t          best;
			res = '0;
			case (mode)
				MODE_LOAD: begin
					ref_img[row*SIDE + col]  = rd;
					eval_img[row*SIDE + col] = ed;
				end
				MODE_CLEAR: pass_total = '0;
				MODE_EVAL: begin
					if (row < RADIUS || col < RADIUS || row + RADIUS > SIDE || col + RADIUS > SIDE) begin
						res.edge_error = 1'b1;
					end else begin
						best      = min_gamma_sq(row, col);
						res.gamma = floor_root(best);
						if (best <= u64_t'(ONE_SQ)) begin
							res.passed = 1'b1;
							if (pass_total != COUNT_MAX)
								pass_total++;
						end
					end
				end
				// unused mode three writes nothing
				default: ;
			endcase
			res.pass_count = pass_total;
			pending_gammas.push_back(res);
		endfunction

		function void check_result(logic [OUT_W-1:0] word);
			gamma_result_t got, want;
			got.gamma      = word[15:0];
			got.passed     = word[16];
			got.pass_count = word[33:17];
			got.edge_error = word[34];
			if (pending_gammas.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: gamma %0d passed %0b count %0d edge %0b",
						got.gamma, got.passed, got.pass_count, got.edge_error);
				return;
			end
			want = pending_gammas.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"result mismatch: expected gamma %0d passed %0b count %0d edge %0b,",
						" got gamma %0d passed %0b count %0d edge %0b"},
						want.gamma, want.passed, want.pass_count, want.edge_error,
						got.gamma, got.passed, got.pass_count, got.edge_error);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic [MODE_W-1:0] s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [15:0]      cfg_data;

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit long_hold_req = 1'b0;

	gamma_window_check window_check = new();

	gamma_index_window_min dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#60000000;
		$display("FAILURE");
		$finish;
	end

	// called right after a falling edge, returns right after one with valid still high
	task automatic send_request(input logic [MODE_W-1:0] mode, input int row, input int col,
			input logic [DOSE_W-1:0] rd, input logic [DOSE_W-1:0] ed);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {ed, rd, col[COORD_W-1:0], row[COORD_W-1:0]};
		do @(posedge clk); while (!s_tready);
		window_check.note_request(mode, row, col, rd, ed);
		@(negedge clk);
	endtask

	task automatic load(input int row, input int col, input logic [DOSE_W-1:0] rd,
			input logic [DOSE_W-1:0] ed);
		send_request(MODE_LOAD, row, col, rd, ed);
	endtask

	task automatic evaluate(input int row, input int col);
		send_request(MODE_EVAL, row, col, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
	endtask

	task automatic clear_count();
		send_request(MODE_CLEAR, $urandom_range(SIDE-1), $urandom_range(SIDE-1),
			16'($urandom_range(65535)), 16'($urandom_range(65535)));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (window_check.pending_gammas.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		window_check.set_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// doses close to one another, now and then anywhere
	function automatic logic [DOSE_W-1:0] near_dose();
		if ($urandom_range(9) == 0)
			return 16'($urandom_range(65535));
		return 16'(8192 + $urandom_range(600) - 300);
	endfunction

	task automatic random_request();
		int pick, r, c;
		pick = $urandom_range(99);
		r = $urandom_range(SIDE-1);
		c = $urandom_range(SIDE-1);
		if (pick < 30) begin
			load($urandom_range(BLK_HI, BLK_LO), $urandom_range(BLK_HI, BLK_LO), near_dose(), near_dose());
		end else if (pick < 55) begin
			load(r, c, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
		end else if (pick < 82) begin
			// push the window off the image on at least one side
			case ($urandom_range(3))
				0: r = $urandom_range(RADIUS-1);
				1: r = $urandom_range(SIDE-1, SIDE-RADIUS+1);
				2: c = $urandom_range(RADIUS-1);
				default: c = $urandom_range(SIDE-1, SIDE-RADIUS+1);
			endcase
			evaluate(r, c);
		end else if (pick < 90) begin
			clear_count();
		end else begin
			send_request(MODE_UNUSED, r, c, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
		end
	endtask

	task automatic run_phase(input int count, input bit full_eval);
		int i;
		for (i = 0; i < count; i++) begin
			if (full_eval && i == count/2)
				evaluate($urandom_range(CTR_HI, CTR_LO), $urandom_range(CTR_HI, CTR_LO));
			else
				random_request();
		end
		drain();
	endtask

	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			window_check.check_result(m_tdata);
	end

	initial begin : stimulus
		int r, c, i;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = MODE_LOAD;
		cfg_valid = 1'b0;
		cfg_index = CFG_DIST_CRIT;
		cfg_data  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill the block that full evaluations read
		for (r = BLK_LO; r <= BLK_HI; r++)
			for (c = BLK_LO; c <= BLK_HI; c++)
				load(r, c, near_dose(), near_dose());

		load(0, 0, 16'h0000, 16'h0000);
		load(SIDE-1, SIDE-1, 16'hffff, 16'hffff);
		load(0, SIDE-1, 16'haaaa, 16'h5555);
		load(SIDE-1, 0, 16'h5555, 16'haaaa);
		evaluate(0, 0);
		evaluate(SIDE-1, SIDE-1);
		evaluate(RADIUS-1, CTR_LO);
		evaluate(CTR_LO, RADIUS-1);
		evaluate(SIDE-RADIUS+1, CTR_LO);
		evaluate(CTR_LO, SIDE-RADIUS+1);
		// mode three must leave the center untouched
		send_request(MODE_UNUSED, CTR_LO, CTR_LO, 16'hffff, 16'hffff);
		evaluate(CTR_LO, CTR_LO);
		// center far from nearly every neighbor: gamma at or near the cap
		load(CTR_HI, CTR_HI, 16'hffff, 16'h0000);
		evaluate(CTR_HI, CTR_HI);
		clear_count();
		send_request(MODE_UNUSED, 7, 200, 16'h1234, 16'hfedc);
		evaluate(SIDE-1, 0);
		clear_count();
		drain();

		// zero criteria are taken as one
		send_idle_pct = 82;
		stall_pct = 0;
		write_reg(CFG_DIST_CRIT, {8'($urandom_range(255)), 8'd0});
		write_reg(CFG_DOSE_CRIT, 16'd0);
		run_phase(90, 1'b1);

		send_idle_pct = 0;
		stall_pct = 82;
		write_reg(CFG_DIST_CRIT, {8'($urandom_range(255)), 8'd255});
		write_reg(CFG_DOSE_CRIT, 16'hffff);
		run_phase(45, 1'b1);
		// pause until everything is back, then go on
		drain();
		run_phase(45, 1'b0);

		send_idle_pct = 38;
		stall_pct = 38;
		write_reg(CFG_DIST_CRIT, {8'($urandom_range(255)), 8'd1});
		write_reg(CFG_DOSE_CRIT, 16'd1);
		run_phase(90, 1'b1);

		send_idle_pct = 0;
		stall_pct = 0;
		write_reg(CFG_DIST_CRIT, {8'($urandom_range(255)), 8'($urandom_range(254, 2))});
		write_reg(CFG_DOSE_CRIT, 16'($urandom_range(65534, 2)));
		// hold the output long enough that requests back up
		long_hold_req = 1'b1;
		for (i = 0; i < 30; i++)
			load($urandom_range(SIDE-1), $urandom_range(SIDE-1),
				16'($urandom_range(65535)), 16'($urandom_range(65535)));
		run_phase(60, 1'b0);

		drain();
		repeat (20) @(posedge clk);
		if (window_check.mismatches == 0 && window_check.pending_gammas.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== gamma_index_window_min.f =====
rtl/core/giwm_pkg.sv
rtl/core/gamma_index_window_min.sv
tb/sv/gamma_index_window_min_tb.sv
